// ===== design/edig_pkg.sv =====
// ----------------------------------------------------------------------------
// edig_pkg
// Shared widths, codes and limits for the element dof index generator.
// ----------------------------------------------------------------------------
package edig_pkg;

	localparam int ORDER_W  = 3;
	localparam int EPS_W    = 6;
	localparam int COORD_W  = 6;
	localparam int KIND_W   = 2;
	localparam int TIDX_W   = 12;
	localparam int TVAL_W   = 32;
	localparam int DOF_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam int MAX_ORDER     = 7;
	localparam int MAX_DOFS_SIDE = 63;
	localparam int ADDR_W = $clog2((MAX_DOFS_SIDE + 1) * (MAX_DOFS_SIDE + 1));
	localparam int CNT_W  = ORDER_W + 1;
	localparam int MAX_PTS = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_ORDER     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENTS_PER_SIDE = 1'd1;

	localparam logic ACT_GENERATE = 1'b0;
	localparam logic ACT_LOAD     = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NODE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_XEDGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_YEDGE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FACE  = 2'd3;

endpackage

// ===== design/element_dof_index_generator_core.sv =====
// ----------------------------------------------------------------------------
// element_dof_index_generator_core
// Emits the dof indices of one element of a square structured grid, local
// or looked up in a loaded local-to-global map, one index per result.
// ----------------------------------------------------------------------------
// channel | signals                         | direction | payload
// in      | in_valid / in_ready             | input     | action kind use_global
//         |                                 |           | elem_x elem_y table_index
//         |                                 |           | table_value
// out     | out_valid / out_ready           | output    | dof_index last error
// cfg     | cfg_wr_en / cfg_addr / cfg_wdata| input     | element_order,
//         |                                 |           | elements_per_side
//
// Load request: taken while idle, one write port of the map memory.
// Generate request: setup states S_SET1, S_SET2 and S_SET3 (size, limit and base
// multiplies), then rows*cols indices, one index per cycle unless the output stalls.
// Bad request: setup states S_SET1 to S_SET3, then a single error result.
// Results pass a read stage and an output register; a stall holds both.
// No clearing pass after reset: the user must write map entries before they are read (not enforced).
// ----------------------------------------------------------------------------
module element_dof_index_generator_core #(
	parameter int MAP_DEPTH   = 4096,
	parameter int INDEX_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [edig_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [edig_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic [edig_pkg::KIND_W-1:0]            kind,
	input  logic                                   use_global,
	input  logic [edig_pkg::COORD_W-1:0]           elem_x,
	input  logic [edig_pkg::COORD_W-1:0]           elem_y,
	input  logic [edig_pkg::TIDX_W-1:0]            table_index,
	input  logic [edig_pkg::TVAL_W-1:0]            table_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [edig_pkg::DOF_W-1:0]             dof_index,
	output logic                                   last,
	output logic                                   error
);
	import edig_pkg::*;

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int MW = (INDEX_WIDTH < TVAL_W) ? INDEX_WIDTH : TVAL_W;
	localparam int MEM_AW = AW + KIND_W;
	localparam int D_W   = ORDER_W + EPS_W;
	localparam int STR_W = D_W + 1;
	localparam int SQ_W  = 2 * STR_W;
	localparam int LV_W  = ADDR_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SET1 = 3'd1;
	localparam logic [2:0] S_SET2 = 3'd2;
	localparam logic [2:0] S_SET3 = 3'd3;
	localparam logic [2:0] S_RUN  = 3'd4;
	localparam logic [2:0] S_ERR  = 3'd5;

	logic [2:0]          state_q;
	logic [ORDER_W-1:0]  order_q;
	logic [EPS_W-1:0]    eps_q;

	logic [KIND_W-1:0]   kind_q;
	logic                glob_q;
	logic [COORD_W-1:0]  ex_q;
	logic [COORD_W-1:0]  ey_q;
	logic [D_W-1:0]      d_q;
	logic [D_W-1:0]      eyp_q;
	logic [D_W-1:0]      exp_q;
	logic                bad0_q;
	logic                bad1_q;
	logic [STR_W-1:0]    stride_q;
	logic [ADDR_W-1:0]   rowbase_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    rows_q;
	logic [CNT_W-1:0]    cols_q;
	logic [CNT_W-1:0]    ix_q;
	logic [CNT_W-1:0]    iy_q;

	logic                s1_valid_q;
	logic                last_s1;
	logic                err_s1;
	logic                glob_s1;
	logic [LV_W-1:0]     lval_s1;
	logic [MW-1:0]       rdata_s1;

	logic                out_valid_q;
	logic [DOF_W-1:0]    dof_index_q;
	logic                last_q;
	logic                error_q;

	logic [MW-1:0]       map_mem [1 << MEM_AW];

	logic                in_fire;
	logic                adv;
	logic                issue;
	logic                run_last;
	logic                row_end;
	logic                is_pp1;
	logic                col_pp1;
	logic [CNT_W-1:0]    p1;
	logic [2*CNT_W-1:0]  p1sq;
	logic [D_W-1:0]      d_c;
	logic [STR_W-1:0]    stride_c;
	logic [SQ_W-1:0]     dsq_c;
	logic [LV_W-1:0]     lval_c;
	logic                tidx_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign adv       = !out_valid_q || out_ready;
	assign issue     = adv && (state_q == S_RUN || state_q == S_ERR);
	assign row_end   = (ix_q == cols_q - CNT_W'(1));
	assign run_last  = row_end && (iy_q == rows_q - CNT_W'(1));

	assign is_pp1  = (kind == KIND_NODE) || (kind == KIND_YEDGE);
	assign col_pp1 = (kind_q == KIND_NODE) || (kind_q == KIND_XEDGE);
	assign p1      = CNT_W'(order_q) + CNT_W'(1);
	assign p1sq    = p1 * p1;
	assign d_c     = D_W'(order_q) * D_W'(eps_q);
	assign stride_c = col_pp1 ? STR_W'(d_q) + STR_W'(1) : STR_W'(d_q);
	assign dsq_c   = (SQ_W'(d_q) + SQ_W'(1)) * (SQ_W'(d_q) + SQ_W'(1));
	assign tidx_ok = 32'(table_index) < 32'(MAP_DEPTH);

	always_comb begin
		case (kind_q)
			KIND_XEDGE: lval_c = {addr_q, 1'b0};
			KIND_YEDGE: lval_c = {addr_q, 1'b1};
			default:    lval_c = LV_W'(addr_q);
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
			eps_q   <= EPS_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_ELEMENT_ORDER:     order_q <= cfg_wdata[ORDER_W-1:0];
				REG_ELEMENTS_PER_SIDE: eps_q   <= cfg_wdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ix_q    <= '0;
			iy_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && action == ACT_GENERATE) begin
						state_q <= S_SET1;
					end
				end
				S_SET1: state_q <= S_SET2;
				S_SET2: state_q <= S_SET3;
				S_SET3: begin
					ix_q    <= '0;
					iy_q    <= '0;
					state_q <= (bad0_q || bad1_q || d_q > D_W'(MAX_DOFS_SIDE)) ?
						S_ERR : S_RUN;
				end
				S_RUN: begin
					if (adv) begin
						if (row_end) begin
							ix_q <= '0;
							iy_q <= iy_q + CNT_W'(1);
						end else begin
							ix_q <= ix_q + CNT_W'(1);
						end
						if (run_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and address datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind;
			glob_q <= use_global;
			ex_q   <= elem_x;
			ey_q   <= elem_y;
			rows_q <= is_pp1 ? CNT_W'(order_q) + CNT_W'(1) : CNT_W'(order_q);
			cols_q <= (kind == KIND_NODE || kind == KIND_XEDGE) ?
				CNT_W'(order_q) + CNT_W'(1) : CNT_W'(order_q);
		end
		if (state_q == S_SET1) begin
			d_q    <= d_c;
			eyp_q  <= D_W'(ey_q) * D_W'(order_q);
			exp_q  <= D_W'(ex_q) * D_W'(order_q);
			bad0_q <= (order_q == '0) || (CNT_W'(order_q) > CNT_W'(MAX_ORDER)) ||
				(eps_q == '0) || (ex_q >= eps_q) || (ey_q >= eps_q) ||
				(p1sq > (2*CNT_W)'(MAX_PTS));
		end
		if (state_q == S_SET2) begin
			stride_q  <= stride_c;
			rowbase_q <= ADDR_W'(eyp_q) * ADDR_W'(stride_c) + ADDR_W'(exp_q);
			bad1_q    <= glob_q && (32'(dsq_c) > 32'(MAP_DEPTH));
		end
		if (state_q == S_SET3) begin
			addr_q <= rowbase_q;
		end
		if (state_q == S_RUN && adv) begin
			if (row_end) begin
				rowbase_q <= rowbase_q + ADDR_W'(stride_q);
				addr_q    <= rowbase_q + ADDR_W'(stride_q);
			end else begin
				addr_q <= addr_q + ADDR_W'(1);
			end
		end
	end

	// map memory: loads only while idle, reads only while running
	always_ff @(posedge clk) begin
		if (in_fire && action == ACT_LOAD && tidx_ok) begin
			map_mem[{kind, AW'(table_index)}] <= table_value[MW-1:0];
		end
		if (issue && state_q == S_RUN && glob_q) begin
			rdata_s1 <= map_mem[{kind_q, AW'(addr_q)}];
		end
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q  <= issue;
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			err_s1  <= (state_q == S_ERR);
			last_s1 <= (state_q == S_ERR) || run_last;
			glob_s1 <= glob_q;
			lval_s1 <= lval_c;
		end
		if (adv && s1_valid_q) begin
			last_q  <= last_s1;
			error_q <= err_s1;
			if (err_s1) begin
				dof_index_q <= '0;
			end else if (glob_s1) begin
				dof_index_q <= DOF_W'(rdata_s1);
			end else begin
				dof_index_q <= DOF_W'(lval_s1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dof_index = dof_index_q;
	assign last      = last_q;
	assign error     = error_q;

`ifndef SYNTHESIS
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && dof_index == '0)
		else $error("error result not a single zero last result");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_LOAD |=> state_q == S_IDLE)
		else $error("load request started a run");

	a_run_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> ix_q < cols_q && iy_q < rows_q)
		else $error("index counters out of range");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(lval_s1) && $stable(last_s1))
		else $error("read stage lost data under stall");
`endif

endmodule
